// ===== design/accel_magnitude_step_detector_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the accelerometer magnitude step detector
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ACCEL_MAGNITUDE_STEP_DETECTOR_UNIT_ASSERT_SVH
`define ACCEL_MAGNITUDE_STEP_DETECTOR_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, reset-qualified.
`define AMSD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("step detector check failed");
// Next-cycle implication, reset-qualified.
`define AMSD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("step detector check failed");
`else
`define AMSD_ASSERT_NOW(label, clk, rstn, ante, cons)
`define AMSD_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== design/amsd_pkg.sv =====
// ----------------------------------------------------------------------------
// amsd_pkg
// Widths, reset values, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package amsd_pkg;

    localparam int unsigned AXIS_W    = 16;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned MAG_W     = 16;
    localparam int unsigned FIX_W     = 32;
    localparam int unsigned DYN_W     = 34;
    localparam int unsigned PROD_W    = 50;
    localparam int unsigned TALLY_W   = 32;
    localparam int unsigned CNT_W     = 4;
    localparam int unsigned S_TDATA_W = 80;
    localparam int unsigned M_TDATA_W = 40;

    localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd3604;
    localparam logic [CFG_W-1:0] INTERVAL_RST  = 16'd300;
    localparam logic [CFG_W-1:0] WEIGHT_RST    = 16'd3277;
    localparam logic [FIX_W-1:0] GRAVITY_RST   = 32'h4000_0000;  // 1 g in 16.16
    localparam logic [FIX_W-1:0] ROOT_BIT_INIT = 32'h4000_0000;

    localparam logic [CNT_W-1:0] SQ_LAST   = 4'd3;
    localparam logic [CNT_W-1:0] ROOT_LAST = 4'd15;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_WEIGH,
        ST_GRAV,
        ST_DECIDE
    } state_t;

endpackage

// ===== design/accel_magnitude_step_detector_unit.sv =====
// ----------------------------------------------------------------------------
// accel_magnitude_step_detector_unit
// Each sample is squared per axis, put through a 16-step square root loop, then
// weighed into the gravity estimate and decided; the square root loop dominates,
// and a new sample is taken only once the sequencer is back in idle.
// The next item is taken while the previous result waits on m_tready.
// Reset (aresetn low, synchronous): registers to defaults, gravity to 1 g,
// step count, last step time and previous dynamic value to zero.
// ----------------------------------------------------------------------------
`include "accel_magnitude_step_detector_unit_assert.svh"

module accel_magnitude_step_detector_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // sample in: accel_x[15:0], accel_y[31:16], accel_z[47:32], time_ms[79:48]
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [amsd_pkg::S_TDATA_W-1:0]         s_tdata,
    // result out: step_found[0], step_total[32:1], zero pad[39:33]
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [amsd_pkg::M_TDATA_W-1:0]         m_tdata,
    // register write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [amsd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [amsd_pkg::CFG_W-1:0]             cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers: always writable, index 3 is dropped.
    // ------------------------------------------------------------------
    logic [amsd_pkg::CFG_W-1:0] threshold_reg, interval_reg, weight_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= amsd_pkg::THRESHOLD_RST;
            interval_reg  <= amsd_pkg::INTERVAL_RST;
            weight_reg    <= amsd_pkg::WEIGHT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                amsd_pkg::CFG_THRESHOLD: threshold_reg <= cfg_data;
                amsd_pkg::CFG_INTERVAL:  interval_reg  <= cfg_data;
                amsd_pkg::CFG_WEIGHT:    weight_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input field unpack and absolute value (-32768 maps to 32768).
    // ------------------------------------------------------------------
    logic signed [amsd_pkg::AXIS_W-1:0] accel_x, accel_y, accel_z;
    logic [amsd_pkg::TIME_W-1:0]        time_ms;
    logic [amsd_pkg::AXIS_W-1:0]        abs_x, abs_y, abs_z;

    assign accel_x = s_tdata[15:0];
    assign accel_y = s_tdata[31:16];
    assign accel_z = s_tdata[47:32];
    assign time_ms = s_tdata[79:48];

    assign abs_x = accel_x[15] ? (16'd0 - accel_x) : accel_x;
    assign abs_y = accel_y[15] ? (16'd0 - accel_y) : accel_y;
    assign abs_z = accel_z[15] ? (16'd0 - accel_z) : accel_z;

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    amsd_pkg::state_t state_reg, state_next;

    logic [amsd_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [amsd_pkg::AXIS_W-1:0]  ax_reg, ay_reg, az_reg;
    logic [amsd_pkg::TIME_W-1:0]  now_reg;
    logic [amsd_pkg::FIX_W-1:0]   sum_reg, sum_next;
    logic [amsd_pkg::FIX_W-1:0]   rem_reg, rem_next;
    logic [amsd_pkg::FIX_W-1:0]   root_reg, root_next;
    logic [amsd_pkg::FIX_W-1:0]   bit_reg, bit_next;
    logic signed [amsd_pkg::PROD_W-1:0] prod_reg;

    // Detector state
    logic [amsd_pkg::FIX_W-1:0]         gravity_reg, gravity_next;
    logic signed [amsd_pkg::DYN_W-1:0]  prev_dyn_reg, prev_dyn_next;
    logic [amsd_pkg::TIME_W-1:0]        last_step_reg, last_step_next;
    logic [amsd_pkg::TALLY_W-1:0]       tally_reg, tally_next;

    // Output register
    logic                               out_valid_reg, out_valid_next;
    logic                               out_step_reg, out_step_next;
    logic [amsd_pkg::TALLY_W-1:0]       out_total_reg, out_total_next;

    // ------------------------------------------------------------------
    // Shared multiplier: squares of the axes, then the gravity update.
    // Product is always registered before use.
    // ------------------------------------------------------------------
    logic signed [amsd_pkg::DYN_W-1:0]  mul_a;
    logic signed [16:0]                 mul_b;
    logic signed [50:0]                 mul_out;
    logic [amsd_pkg::AXIS_W-1:0]        sq_sel;
    logic [amsd_pkg::FIX_W-1:0]         mag_fx;
    logic signed [amsd_pkg::DYN_W-1:0]  grav_diff;

    assign mag_fx    = {root_reg[amsd_pkg::MAG_W-1:0], 16'd0};
    assign grav_diff = $signed({2'b00, mag_fx}) - $signed({2'b00, gravity_reg});

    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    sq_sel = ax_reg;
            2'd1:    sq_sel = ay_reg;
            default: sq_sel = az_reg;
        endcase
        if (state_reg == amsd_pkg::ST_WEIGH) begin
            mul_a = grav_diff;
            mul_b = $signed({1'b0, weight_reg});
        end else begin
            mul_a = $signed({18'd0, sq_sel});
            mul_b = $signed({1'b0, sq_sel});
        end
        mul_out = mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_out[amsd_pkg::PROD_W-1:0];
    end

    // ------------------------------------------------------------------
    // Square root step, gravity update and step decision
    // ------------------------------------------------------------------
    logic [amsd_pkg::FIX_W-1:0]         trial;
    logic [amsd_pkg::DYN_W-1:0]         grav_sum;
    logic signed [amsd_pkg::DYN_W-1:0]  dyn, thr;
    logic [amsd_pkg::TIME_W-1:0]        elapsed;
    logic                               step_hit;
    logic                               out_free;

    assign trial    = root_reg + bit_reg;
    assign grav_sum = {2'b00, gravity_reg} + prod_reg[amsd_pkg::PROD_W-1:16];
    assign dyn      = $signed({2'b00, mag_fx}) - $signed({2'b00, gravity_reg});
    assign thr      = $signed({2'b00, threshold_reg, 16'd0});
    assign elapsed  = now_reg - last_step_reg;
    assign step_hit = (dyn > thr) && (prev_dyn_reg <= thr)
                      && (elapsed >= {16'd0, interval_reg});
    assign out_free = !out_valid_reg || m_tready;

    assign s_tready = (state_reg == amsd_pkg::ST_IDLE);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            amsd_pkg::ST_IDLE:
                if (s_tvalid) state_next = amsd_pkg::ST_SQUARE;
            amsd_pkg::ST_SQUARE:
                if (cnt_reg == amsd_pkg::SQ_LAST) state_next = amsd_pkg::ST_ROOT;
            amsd_pkg::ST_ROOT:
                if (cnt_reg == amsd_pkg::ROOT_LAST) state_next = amsd_pkg::ST_WEIGH;
            amsd_pkg::ST_WEIGH:
                state_next = amsd_pkg::ST_GRAV;
            amsd_pkg::ST_GRAV:
                state_next = amsd_pkg::ST_DECIDE;
            amsd_pkg::ST_DECIDE:
                if (out_free) state_next = amsd_pkg::ST_IDLE;
            default:
                state_next = amsd_pkg::ST_IDLE;
        endcase
    end

    // Datapath and state updates
    always_comb begin
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        gravity_next   = gravity_reg;
        prev_dyn_next  = prev_dyn_reg;
        last_step_next = last_step_reg;
        tally_next     = tally_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_step_next  = out_step_reg;
        out_total_next = out_total_reg;
        case (state_reg)
            amsd_pkg::ST_IDLE: begin
                cnt_next = '0;
                sum_next = '0;
            end
            amsd_pkg::ST_SQUARE: begin
                // accumulate the square computed in the previous cycle
                if (cnt_reg != '0) sum_next = sum_reg + prod_reg[amsd_pkg::FIX_W-1:0];
                if (cnt_reg == amsd_pkg::SQ_LAST) begin
                    rem_next  = sum_reg + prod_reg[amsd_pkg::FIX_W-1:0];
                    root_next = '0;
                    bit_next  = amsd_pkg::ROOT_BIT_INIT;
                    cnt_next  = '0;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            amsd_pkg::ST_ROOT: begin
                // one restoring digit per cycle
                if (rem_reg >= trial) begin
                    rem_next  = rem_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end else begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 4'd1;
            end
            amsd_pkg::ST_GRAV: begin
                gravity_next = grav_sum[amsd_pkg::FIX_W-1:0];
            end
            amsd_pkg::ST_DECIDE: begin
                if (out_free) begin
                    prev_dyn_next  = dyn;
                    if (step_hit) begin
                        last_step_next = now_reg;
                        tally_next     = tally_reg + 32'd1;
                    end
                    out_valid_next = 1'b1;
                    out_step_next  = step_hit;
                    out_total_next = step_hit ? tally_reg + 32'd1 : tally_reg;
                end
            end
            default: ;
        endcase
    end

    // Control and detector state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= amsd_pkg::ST_IDLE;
            cnt_reg       <= '0;
            gravity_reg   <= amsd_pkg::GRAVITY_RST;
            prev_dyn_reg  <= '0;
            last_step_reg <= '0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            gravity_reg   <= gravity_next;
            prev_dyn_reg  <= prev_dyn_next;
            last_step_reg <= last_step_next;
            tally_reg     <= tally_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            ax_reg  <= abs_x;
            ay_reg  <= abs_y;
            az_reg  <= abs_z;
            now_reg <= time_ms;
        end
        sum_reg       <= sum_next;
        rem_reg       <= rem_next;
        root_reg      <= root_next;
        bit_reg       <= bit_next;
        out_step_reg  <= out_step_next;
        out_total_reg <= out_total_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_total_reg, out_step_reg};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `AMSD_ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_tvalid && s_tready,
        state_reg == amsd_pkg::ST_SQUARE)
    `AMSD_ASSERT_NEXT(a_tally_step, aclk, aresetn, state_reg == amsd_pkg::ST_DECIDE && out_free,
        tally_reg == $past(tally_reg) + {31'd0, out_step_reg})
    `AMSD_ASSERT_NEXT(a_gravity_frozen, aclk, aresetn,
        state_reg == amsd_pkg::ST_GRAV && weight_reg == 16'd0,
        gravity_reg == $past(gravity_reg))
    `AMSD_ASSERT_NOW(a_root_floor, aclk, aresetn, state_reg == amsd_pkg::ST_WEIGH,
        {16'd0, root_reg[15:0]} * {16'd0, root_reg[15:0]} <= sum_reg)

endmodule
